/* sv/radio_status_frame_receiver_top_assert.svh */
// Assertion macros for the radio status frame receiver
`ifndef RADIO_STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define RADIO_STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RSFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsfr assertion failed");

// next-cycle implication, checked outside reset
`define RSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsfr assertion failed");

`endif

/* sv/rsfr_pkg.sv */
// Types, constants and helper functions of the radio status frame receiver
package rsfr_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [7:0]  HEADER_RESET  = 8'hA5;
  localparam logic [7:0]  PROTO_RESET   = 8'h14;
  localparam int          NUM_SLOTS     = 7;
  localparam int          SLOT_W        = 3;
  localparam int          POS_W         = 10;

  localparam logic [0:0] CFG_HEADER   = 1'b0;
  localparam logic [0:0] CFG_PROTOCOL = 1'b1;

  localparam logic [6:0] MSG_VERSION = 7'd0;
  localparam logic [6:0] MSG_VOLUME  = 7'd3;
  localparam logic [6:0] MSG_SQUELCH = 7'd4;
  localparam logic [6:0] MSG_DUAL    = 7'd12;
  localparam logic [6:0] MSG_SUPPLY  = 7'd21;
  localparam logic [6:0] MSG_FREQ    = 7'd22;
  localparam logic [6:0] MSG_STATE   = 7'd64;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_CRC_FAIL  = 3'd1;
  localparam logic [2:0] EV_DECODED   = 3'd2;
  localparam logic [2:0] EV_DUPLICATE = 3'd3;
  localparam logic [2:0] EV_SUPPRESS  = 3'd4;

  typedef struct packed {
    logic        id_load;
    logic [6:0]  id;
    logic        done;
    logic        crc_ok;
    logic [15:0] crc;
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [7:0]  b6;
    logic [7:0]  b7;
  } frame_stat_t;

  typedef struct packed {
    logic              known;
    logic [SLOT_W-1:0] slot;
  } slot_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic slot_t slot_of(input logic [6:0] id);
    slot_t s;
    s.known = 1'b1;
    s.slot  = '0;
    unique case (id)
      MSG_VERSION: s.slot = 3'd0;
      MSG_VOLUME:  s.slot = 3'd1;
      MSG_SQUELCH: s.slot = 3'd2;
      MSG_DUAL:    s.slot = 3'd3;
      MSG_SUPPLY:  s.slot = 3'd4;
      MSG_FREQ:    s.slot = 3'd5;
      MSG_STATE:   s.slot = 3'd6;
      default:     s.known = 1'b0;
    endcase
    return s;
  endfunction

  // (50 - b) / 5 truncated toward zero, via reciprocal 205/1024
  function automatic logic [6:0] volume_of(input logic [7:0] b);
    logic [7:0]  d;
    logic [15:0] p;
    logic        neg;
    neg = (b > 8'd50);
    d   = neg ? (b - 8'd50) : (8'd50 - b);
    p   = 16'(d) * 16'd205;
    return neg ? (7'd0 - 7'(p >> 10)) : 7'(p >> 10);
  endfunction

  // (b - 6) / 2 truncated toward zero, plus one
  function automatic logic [7:0] squelch_of(input logic [7:0] b);
    logic [9:0] x;
    logic [9:0] q;
    x = {2'b00, b} - 10'd6;
    q = x[9] ? (10'd0 - ((10'd0 - x) >> 1)) : (x >> 1);
    return 8'(q + 10'd1);
  endfunction

endpackage

/* sv/rsfr_crc_mem.sv */
// Memory of the last accepted CRC per message type, with per-entry valid bits
module rsfr_crc_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [rsfr_pkg::SLOT_W-1:0] rd_slot,
  output logic [15:0]               rd_data,
  input  logic                      wr_en,
  input  logic [rsfr_pkg::SLOT_W-1:0] wr_slot,
  input  logic [15:0]               wr_data
);

  logic [15:0]                    mem_r [rsfr_pkg::NUM_SLOTS];
  logic [rsfr_pkg::NUM_SLOTS-1:0] valid_r;
  logic [15:0]                    rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_slot] ? mem_r[rd_slot] : 16'h0000;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/rsfr_frame.sv */
// Byte framing, CRC accumulation and payload capture
module rsfr_frame #(
  parameter int BUFFER_SIZE = 127
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            header_byte,
  input  logic [7:0]            protocol_byte,
  output rsfr_pkg::frame_stat_t stat
);

  localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
  localparam int PW    = rsfr_pkg::POS_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       pay_r [5];
  logic [7:0]       pay_nxt [5];

  logic [CNT_W-1:0] pos;
  logic [PW-1:0]    pos_x;
  logic [PW-1:0]    len_x;
  logic [15:0]      crc_base;
  logic             done;

  always_comb begin
    pos = (rx_byte == header_byte) ? '0 : cnt_r;
    if (PW'(pos) >= PW'(BUFFER_SIZE)) begin
      pos = '0;
    end
    pos_x    = PW'(pos);
    len_nxt  = (pos_x == PW'(2)) ? rx_byte : len_r;
    len_x    = PW'(len_nxt);
    crc_base = (pos_x == '0) ? 16'h0000 : crc_r;
    crc_nxt  = ((pos_x < PW'(3)) || (pos_x < len_x + PW'(3))) ?
               rsfr_pkg::crc_byte(crc_base, rx_byte) : crc_base;
    hi_nxt   = ((pos_x >= PW'(3)) && (pos_x == len_x + PW'(3))) ? rx_byte : hi_r;
    for (int i = 0; i < 5; i++) begin
      pay_nxt[i] = pay_r[i];
    end
    if ((pos_x >= PW'(3)) && (pos_x <= PW'(7))) begin
      pay_nxt[3'(pos_x - PW'(3))] = rx_byte;
    end
    done    = 1'b0;
    cnt_nxt = CNT_W'(pos_x + PW'(1));
    priority if (pos_x == PW'(1)) begin
      if (rx_byte != protocol_byte) begin
        cnt_nxt = '0;
      end
    end else if ((pos_x >= PW'(2)) && (pos_x + PW'(1) >= len_x + PW'(5))) begin
      done    = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
      crc_r <= '0;
      hi_r  <= '0;
      for (int i = 0; i < 5; i++) begin
        pay_r[i] <= '0;
      end
    end else if (step) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      hi_r  <= hi_nxt;
      for (int i = 0; i < 5; i++) begin
        pay_r[i] <= pay_nxt[i];
      end
    end
  end

  always_comb begin
    stat.id_load = step && (pos_x == PW'(3));
    stat.id      = pay_nxt[0][6:0];
    stat.done    = step && done;
    stat.crc_ok  = (crc_nxt == {hi_r, rx_byte});
    stat.crc     = crc_nxt;
    stat.b4      = pay_nxt[1];
    stat.b5      = pay_nxt[2];
    stat.b6      = pay_nxt[3];
    stat.b7      = pay_nxt[4];
  end

endmodule

/* sv/radio_status_frame_receiver_top.sv */
// Top level of the radio status frame receiver: config, duplicate check, decode, output
// Takes one received byte per clock and gives one result per byte, so with a ready sink
// the block sustains one transfer per cycle; each result is registered in the cycle after its byte.
// The result comes from the single update stage: framing, one unrolled CRC byte step and the
// duplicate compare against the per-type CRC memory, whose read is issued when the message id
// byte arrives so its data is ready by the frame's last byte. The CRC memory clears through
// per-entry valid bits at reset, so there is no clearing pass; input is taken right after reset.
module radio_status_frame_receiver_top #(
  parameter int BUFFER_SIZE = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] suppress
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] message_id, [13:7] volume, [21:14] squelch, [22] dual_mode,
  // [30:23] supply_code, [46:31] active_channel, [62:47] standby_channel,
  // [63] transmitting, [64] rx_on_active, [65] rx_on_standby, [66] changed
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,  // [2:0] frame_event
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] header_r, proto_r;
  logic       step;
  logic       out_valid_r;
  logic [2:0] ev_r, ev_nxt;
  logic [6:0] last_id_r, last_id_nxt;

  logic signed [6:0] volume_r, volume_nxt;
  logic signed [7:0] squelch_r, squelch_nxt;
  logic              dual_r, dual_nxt;
  logic [7:0]        supply_r, supply_nxt;
  logic [15:0]       active_r, active_nxt;
  logic [15:0]       standby_r, standby_nxt;
  logic              tx_r, tx_nxt;
  logic              rxa_r, rxa_nxt;
  logic              rxs_r, rxs_nxt;
  logic              changed_r, changed_nxt;

  rsfr_pkg::frame_stat_t fs;
  rsfr_pkg::slot_t       rd_sel;
  rsfr_pkg::slot_t       slot_r;
  logic [15:0]           last_crc;
  logic                  wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= rsfr_pkg::HEADER_RESET;
      proto_r  <= rsfr_pkg::PROTO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rsfr_pkg::CFG_HEADER:   header_r <= cfg_wdata;
        rsfr_pkg::CFG_PROTOCOL: proto_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  rsfr_frame #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_tdata),
    .header_byte  (header_r),
    .protocol_byte(proto_r),
    .stat         (fs)
  );

  assign rd_sel = rsfr_pkg::slot_of(fs.id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (fs.id_load) begin
      slot_r <= rd_sel;
    end
  end

  rsfr_crc_mem u_crc_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (fs.id_load),
    .rd_slot(rd_sel.slot),
    .rd_data(last_crc),
    .wr_en  (wr_en),
    .wr_slot(slot_r.slot),
    .wr_data(fs.crc)
  );

  always_comb begin
    ev_nxt      = rsfr_pkg::EV_NONE;
    last_id_nxt = last_id_r;
    wr_en       = 1'b0;
    volume_nxt  = volume_r;
    squelch_nxt = squelch_r;
    dual_nxt    = dual_r;
    supply_nxt  = supply_r;
    active_nxt  = active_r;
    standby_nxt = standby_r;
    tx_nxt      = tx_r;
    rxa_nxt     = rxa_r;
    rxs_nxt     = rxs_r;
    changed_nxt = changed_r;
    if (fs.done) begin
      last_id_nxt = fs.id;
      priority if (!fs.crc_ok) begin
        ev_nxt = rsfr_pkg::EV_CRC_FAIL;
      end else if (in_tuser[0]) begin
        ev_nxt = rsfr_pkg::EV_SUPPRESS;
      end else if (slot_r.known && (last_crc == fs.crc)) begin
        ev_nxt = rsfr_pkg::EV_DUPLICATE;
      end else begin
        ev_nxt = rsfr_pkg::EV_DECODED;
        wr_en  = slot_r.known;
        unique case (last_id_nxt)
          rsfr_pkg::MSG_VOLUME: begin
            volume_nxt  = rsfr_pkg::volume_of(fs.b4);
            changed_nxt = 1'b1;
          end
          rsfr_pkg::MSG_SQUELCH: begin
            squelch_nxt = rsfr_pkg::squelch_of(fs.b4);
            changed_nxt = 1'b1;
          end
          rsfr_pkg::MSG_DUAL: begin
            dual_nxt    = fs.b4[0];
            changed_nxt = 1'b1;
          end
          rsfr_pkg::MSG_SUPPLY: begin
            supply_nxt  = fs.b4;
            changed_nxt = 1'b1;
          end
          rsfr_pkg::MSG_FREQ: begin
            active_nxt  = {fs.b4, fs.b5};
            standby_nxt = {fs.b6, fs.b7};
            changed_nxt = 1'b1;
          end
          rsfr_pkg::MSG_STATE: begin
            tx_nxt      = fs.b7[5] | fs.b7[6];
            rxa_nxt     = fs.b7[7];
            rxs_nxt     = fs.b6[0];
            changed_nxt = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ev_r        <= rsfr_pkg::EV_NONE;
      last_id_r   <= '0;
      volume_r    <= '0;
      squelch_r   <= '0;
      dual_r      <= 1'b0;
      supply_r    <= '0;
      active_r    <= '0;
      standby_r   <= '0;
      tx_r        <= 1'b0;
      rxa_r       <= 1'b0;
      rxs_r       <= 1'b0;
      changed_r   <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
      ev_r        <= ev_nxt;
      last_id_r   <= last_id_nxt;
      volume_r    <= volume_nxt;
      squelch_r   <= squelch_nxt;
      dual_r      <= dual_nxt;
      supply_r    <= supply_nxt;
      active_r    <= active_nxt;
      standby_r   <= standby_nxt;
      tx_r        <= tx_nxt;
      rxa_r       <= rxa_nxt;
      rxs_r       <= rxs_nxt;
      changed_r   <= changed_nxt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {5'b00000, changed_r, rxs_r, rxa_r, tx_r, standby_r, active_r,
                       supply_r, dual_r, squelch_r, volume_r, last_id_r};

  `include "radio_status_frame_receiver_top_assert.svh"

  `RSFR_ASSERT_IMPL(a_mem_no_clash, fs.id_load, !wr_en)
  `RSFR_ASSERT_NEXT(a_crc_fail_event, fs.done && !fs.crc_ok, out_tuser == rsfr_pkg::EV_CRC_FAIL)
  `RSFR_ASSERT_NEXT(a_changed_sticky, changed_r, changed_r)

endmodule

/* tb/status_frame_checker.sv */
// Status frame checker: CRC helper, byte-level frame predictor and result comparison
package frame_crc_pkg;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ rsfr_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module status_frame_checker #(
  parameter int BUF_LEN = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  output int          mismatches,
  output int          pending
);
  import rsfr_pkg::*;
  import frame_crc_pkg::*;

  typedef struct packed {
    logic [2:0]  frame_event;
    logic [6:0]  msg_id;
    logic [6:0]  volume;
    logic [7:0]  squelch;
    logic        dual;
    logic [7:0]  supply;
    logic [15:0] active_ch;
    logic [15:0] standby_ch;
    logic        tx;
    logic        rx_act;
    logic        rx_stby;
    logic        changed;
  } status_t;

  logic [7:0]  header_r;
  logic [7:0]  proto_r;
  int          byte_cnt;
  int          len_r;
  logic [15:0] crc_r;
  logic [7:0]  crc_hi_r;
  logic [7:0]  stored [5];
  logic [15:0] last_crc [NUM_SLOTS];
  status_t     held;
  status_t     expected_q [$];
  int          failures = 0;
  int          result_idx = 0;

  assign mismatches = failures;
  initial pending = 0;

  function automatic int dedup_slot(input logic [6:0] id);
    case (id)
      MSG_VERSION: return 0;
      MSG_VOLUME:  return 1;
      MSG_SQUELCH: return 2;
      MSG_DUAL:    return 3;
      MSG_SUPPLY:  return 4;
      MSG_FREQ:    return 5;
      MSG_STATE:   return 6;
      default:     return -1;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (failures < 40) begin
      $display("%s", msg);
    end
    failures++;
  endtask

  task automatic predict_status(input logic [7:0] b, input logic sup);
    int          pos;
    int          slot;
    int          v;
    logic [15:0] rcv;
    logic [6:0]  id;
    status_t     r;
    if (b == header_r) begin
      byte_cnt = 0;
    end
    if (byte_cnt >= BUF_LEN) begin
      byte_cnt = 0;
    end
    pos = byte_cnt;
    byte_cnt++;
    if (pos == 0) begin
      crc_r = '0;
    end
    if (pos == 2) begin
      len_r = b;
    end
    if (pos >= 3 && pos <= 7) begin
      stored[pos-3] = b;
    end
    if (pos < 3 || pos < len_r + 3) begin
      crc_r = crc16_next(crc_r, b);
    end
    if (pos >= 3 && pos == len_r + 3) begin
      crc_hi_r = b;
    end
    held.frame_event = EV_NONE;
    if (byte_cnt == 2) begin
      if (b != proto_r) begin
        byte_cnt = 0;
      end
    end else if (byte_cnt >= 3 && byte_cnt >= len_r + 5) begin
      rcv = {crc_hi_r, b};
      id = stored[0][6:0];
      held.msg_id = id;
      if (crc_r != rcv) begin
        held.frame_event = EV_CRC_FAIL;
      end else if (sup) begin
        held.frame_event = EV_SUPPRESS;
      end else begin
        slot = dedup_slot(id);
        if (slot >= 0 && last_crc[slot] == crc_r) begin
          held.frame_event = EV_DUPLICATE;
        end else begin
          if (slot >= 0) begin
            last_crc[slot] = crc_r;
          end
          held.frame_event = EV_DECODED;
          case (id)
            MSG_VOLUME: begin
              v = (50 - int'(stored[1])) / 5;
              held.volume = v[6:0];
              held.changed = 1'b1;
            end
            MSG_SQUELCH: begin
              v = (int'(stored[1]) - 6) / 2 + 1;
              held.squelch = v[7:0];
              held.changed = 1'b1;
            end
            MSG_DUAL: begin
              held.dual = stored[1][0];
              held.changed = 1'b1;
            end
            MSG_SUPPLY: begin
              held.supply = stored[1];
              held.changed = 1'b1;
            end
            MSG_FREQ: begin
              held.active_ch = {stored[1], stored[2]};
              held.standby_ch = {stored[3], stored[4]};
              held.changed = 1'b1;
            end
            MSG_STATE: begin
              held.tx = |(stored[4] & 8'h60);
              held.rx_act = stored[4][7];
              held.rx_stby = stored[3][0];
              held.changed = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      byte_cnt = 0;
    end
    r = held;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_idx, name, got_v, want_v));
    end
  endtask

  task automatic check_status(input status_t want);
    compare_field("frame_event", 16'(out_tuser), 16'(want.frame_event));
    compare_field("message_id", 16'(out_tdata[6:0]), 16'(want.msg_id));
    compare_field("volume", 16'(out_tdata[13:7]), 16'(want.volume));
    compare_field("squelch", 16'(out_tdata[21:14]), 16'(want.squelch));
    compare_field("dual_mode", 16'(out_tdata[22]), 16'(want.dual));
    compare_field("supply_code", 16'(out_tdata[30:23]), 16'(want.supply));
    compare_field("active_channel", out_tdata[46:31], want.active_ch);
    compare_field("standby_channel", out_tdata[62:47], want.standby_ch);
    compare_field("transmitting", 16'(out_tdata[63]), 16'(want.tx));
    compare_field("rx_on_active", 16'(out_tdata[64]), 16'(want.rx_act));
    compare_field("rx_on_standby", 16'(out_tdata[65]), 16'(want.rx_stby));
    compare_field("changed", 16'(out_tdata[66]), 16'(want.changed));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      header_r = HEADER_RESET;
      proto_r = PROTO_RESET;
      byte_cnt = 0;
      len_r = 0;
      crc_r = '0;
      crc_hi_r = '0;
      for (int i = 0; i < 5; i++) begin
        stored[i] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        last_crc[i] = '0;
      end
      held = '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_HEADER:   header_r = cfg_wdata;
          CFG_PROTOCOL: proto_r = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_status(in_tdata, in_tuser[0]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: transfer with nothing expected", result_idx));
        end else begin
          check_status(expected_q.pop_front());
        end
        result_idx++;
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, frame stimulus, sink stalls and the final verdict
module tb;
  import rsfr_pkg::*;
  import frame_crc_pkg::*;

  localparam int FRAME_BUF = 127;
  localparam int MAX_BODY  = FRAME_BUF - 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;
  int          mismatches;
  int          pending;

  logic [7:0]  hdr_cfg = HEADER_RESET;
  logic [7:0]  proto_cfg = PROTO_RESET;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  body_q [$];
  logic [7:0]  frame_q [$];
  logic [6:0]  known_ids [7];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  radio_status_frame_receiver_top #(.BUFFER_SIZE(FRAME_BUF)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  status_frame_checker #(.BUF_LEN(FRAME_BUF)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // hold off the sink for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == hdr_cfg);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sup);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= sup;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] h, input logic [7:0] p);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_HEADER;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_addr <= CFG_PROTOCOL;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_cfg = h;
    proto_cfg = p;
  endtask

  // body_q holds the leading payload bytes; the rest is filled at random
  task automatic make_frame(input logic [7:0] first, input logic [7:0] proto_b, input int len);
    logic [15:0] c;
    frame_q.delete();
    frame_q.push_back(first);
    frame_q.push_back(proto_b);
    frame_q.push_back(8'(len));
    while (body_q.size() < len) begin
      body_q.push_back(body_byte());
    end
    for (int i = 0; i < len; i++) begin
      frame_q.push_back(body_q[i]);
    end
    c = '0;
    foreach (frame_q[i]) begin
      c = crc16_next(c, frame_q[i]);
    end
    frame_q.push_back(c[15:8]);
    frame_q.push_back(c[7:0]);
  endtask

  task automatic send_frame(input logic sup, input int n);
    for (int i = 0; i < n && i < frame_q.size(); i++) begin
      send_byte(frame_q[i], sup);
    end
  endtask

  task automatic send_good(input logic [7:0] id_b, input logic [7:0] b4, input logic [7:0] b5,
                           input logic [7:0] b6, input logic [7:0] b7, input int len,
                           input logic sup);
    logic [7:0] v [5];
    v[0] = id_b;
    v[1] = b4;
    v[2] = b5;
    v[3] = b6;
    v[4] = b7;
    body_q.delete();
    for (int i = 0; i < len && i < 5; i++) begin
      body_q.push_back(v[i]);
    end
    make_frame(hdr_cfg, proto_cfg, len);
    send_frame(sup, frame_q.size());
  endtask

  task automatic run_directed();
    logic [15:0] c;
    // first frame of a type whose CRC is zero counts as a repeat
    c = crc16_next(16'h0, hdr_cfg);
    c = crc16_next(c, proto_cfg);
    c = crc16_next(c, 8'd3);
    c = crc16_next(c, {1'b0, MSG_SUPPLY});
    body_q.delete();
    body_q.push_back({1'b0, MSG_SUPPLY});
    body_q.push_back(c[15:8]);
    body_q.push_back(c[7:0]);
    make_frame(hdr_cfg, proto_cfg, 3);
    send_frame(1'b0, frame_q.size());
    send_good({1'b0, MSG_VOLUME}, 8'd0, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b1, MSG_VOLUME}, 8'd255, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b0, MSG_SQUELCH}, 8'd0, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b0, MSG_SQUELCH}, 8'd255, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b0, MSG_DUAL}, 8'd1, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b0, MSG_SUPPLY}, 8'd255, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    send_good({1'b0, MSG_FREQ}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5, 1'b0);
    send_good({1'b0, MSG_STATE}, 8'h00, 8'h00, 8'h01, 8'hE0, 5, 1'b0);
    send_frame(1'b0, frame_q.size());
    send_good({1'b0, MSG_VERSION}, 8'd0, 8'd0, 8'd0, 8'd0, 1, 1'b0);
    send_good(8'h7F, 8'd9, 8'd0, 8'd0, 8'd0, 3, 1'b0);
    send_good({1'b0, MSG_VOLUME}, 8'd77, 8'd0, 8'd0, 8'd0, 2, 1'b1);
    // bad CRC
    body_q.delete();
    body_q.push_back({1'b0, MSG_DUAL});
    make_frame(hdr_cfg, proto_cfg, 2);
    frame_q[frame_q.size()-1] ^= 8'h01;
    send_frame(1'b0, frame_q.size());
    // short frames read held payload bytes
    send_good(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1'b0);
    send_good({1'b0, MSG_FREQ}, 8'd0, 8'd0, 8'd0, 8'd0, 1, 1'b0);
    // wrong protocol byte, then a start on a non-header byte
    body_q.delete();
    make_frame(hdr_cfg, proto_cfg ^ 8'h01, 2);
    send_frame(1'b0, frame_q.size());
    body_q.delete();
    body_q.push_back({1'b0, MSG_SQUELCH});
    body_q.push_back(8'd30);
    make_frame(8'h00, proto_cfg, 2);
    send_frame(1'b0, frame_q.size());
    // largest frame that completes
    body_q.delete();
    body_q.push_back({1'b0, MSG_SUPPLY});
    make_frame(hdr_cfg, proto_cfg, MAX_BODY);
    send_frame(1'b0, frame_q.size());
    // overrun the buffer
    send_byte(hdr_cfg, 1'b0);
    send_byte(proto_cfg, 1'b0);
    send_byte(8'd255, 1'b0);
    repeat (FRAME_BUF + 3) send_byte(body_byte(), 1'b0);
    // header in mid-frame restarts reception
    body_q.delete();
    body_q.push_back({1'b0, MSG_VOLUME});
    make_frame(hdr_cfg, proto_cfg, 4);
    send_frame(1'b0, 5);
    send_good({1'b0, MSG_VOLUME}, 8'd45, 8'd0, 8'd0, 8'd0, 2, 1'b0);
    drain();
  endtask

  task automatic run_segment(input int n_items);
    int         start;
    int         pick;
    int         len;
    int         k;
    logic       sup;
    logic [7:0] id_b;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(99);
      sup = ($urandom_range(9) == 0);
      id_b = {1'($urandom_range(1)), known_ids[$urandom_range(6)]};
      len = $urandom_range(7);
      body_q.delete();
      if (len > 0) begin
        body_q.push_back(id_b);
      end
      if (pick < 55) begin
        make_frame(hdr_cfg, proto_cfg, len);
        send_frame(sup, frame_q.size());
      end else if (pick < 63) begin
        body_q.delete();
        make_frame(hdr_cfg, proto_cfg, len);
        send_frame(sup, frame_q.size());
      end else if (pick < 71) begin
        if (frame_q.size() == 0) begin
          make_frame(hdr_cfg, proto_cfg, len);
        end
        send_frame(sup, frame_q.size());
      end else if (pick < 78) begin
        make_frame(hdr_cfg, proto_cfg, len);
        k = $urandom_range(frame_q.size() - 1, 3);
        frame_q[k] ^= 8'(1 << $urandom_range(7));
        send_frame(sup, frame_q.size());
      end else if (pick < 86) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 91) begin
        make_frame(hdr_cfg, proto_cfg, len);
        send_frame(sup, $urandom_range(frame_q.size() - 1, 1));
      end else if (pick < 95) begin
        make_frame(hdr_cfg, proto_cfg ^ 8'($urandom_range(255, 1)), len);
        send_frame(sup, frame_q.size());
      end else if (pick < 97) begin
        make_frame(body_byte(), proto_cfg, len);
        send_frame(sup, frame_q.size());
      end else if (pick < 98) begin
        drain();
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(255, MAX_BODY + 1)
                                       : $urandom_range(MAX_BODY, 8);
        make_frame(hdr_cfg, proto_cfg, len);
        send_frame(sup, frame_q.size());
      end
    end
  endtask

  initial begin
    logic [7:0] h;
    logic [7:0] p;
    known_ids[0] = MSG_VERSION;
    known_ids[1] = MSG_VOLUME;
    known_ids[2] = MSG_SQUELCH;
    known_ids[3] = MSG_DUAL;
    known_ids[4] = MSG_SUPPLY;
    known_ids[5] = MSG_FREQ;
    known_ids[6] = MSG_STATE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          h = HEADER_RESET;
          p = PROTO_RESET;
        end
        1: begin
          h = 8'h00;
          p = 8'hFF;
        end
        2: begin
          h = 8'hFF;
          p = 8'h00;
        end
        4: begin
          h = 8'h7E;
          p = 8'h81;
        end
        default: begin
          h = 8'($urandom_range(255));
          do begin
            p = 8'($urandom_range(255));
          end while (p == h);
        end
      endcase
      write_cfg(h, p);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 66;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 66;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct <= 16;
        end
      endcase
      if (seg == 4) begin
        hold_req <= hold_req + 1;
      end
      run_segment(220);
      drain();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/rsfr_pkg.sv
sv/rsfr_crc_mem.sv
sv/rsfr_frame.sv
sv/radio_status_frame_receiver_top.sv
tb/status_frame_checker.sv
tb/tb.sv
